[rtl/core/drt_pkg.sv]
// Shared types and constants of the dirty region tracker.
// Used by drt_clip, drt_state and the dirty_region_tracker top level.
package drt_pkg;

  // Width of one canvas coordinate; covers 0 to 2047 inclusive.
  localparam int unsigned COORD_W = 11;
  // Width of one signed rectangle field on the input.
  localparam int unsigned FIELD_W = 16;
  // Width of the internal clip sums.
  localparam int unsigned SUM_W = FIELD_W + 1;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned DEF_CANVAS_ROWS = 240;
  localparam int unsigned DEF_CANVAS_COLUMNS = 320;
  localparam logic [CFG_W-1:0] FRAME_INTERVAL_RST = 16'd16;
  localparam logic [CFG_W-1:0] FILL_COLOUR_RST = 16'd0;

  typedef enum logic [1:0] {
    CMD_BEGIN    = 2'd0,
    CMD_MARK     = 2'd1,
    CMD_MARK_ALL = 2'd2,
    CMD_RENDER   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_INTERVAL = 1'd0,
    CFG_FILL_COLOUR    = 1'd1
  } cfg_idx_e;

  // Half-open rectangle on the canvas.
  typedef struct packed {
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] right;
  } rect_t;

  typedef struct packed {
    logic               drawn;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] height;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] width;
    logic [CFG_W-1:0]   fill;
  } result_t;

endpackage

[rtl/core/drt_clip.sv]
// Clips a signed rectangle to the canvas and flags an empty result.
// Depends on drt_pkg.
module drt_clip #(
  parameter int unsigned CANVAS_ROWS    = drt_pkg::DEF_CANVAS_ROWS,
  parameter int unsigned CANVAS_COLUMNS = drt_pkg::DEF_CANVAS_COLUMNS
) (
  input  logic signed [drt_pkg::FIELD_W-1:0] top_i,
  input  logic signed [drt_pkg::FIELD_W-1:0] height_i,
  input  logic signed [drt_pkg::FIELD_W-1:0] left_i,
  input  logic signed [drt_pkg::FIELD_W-1:0] width_i,
  output logic                               nonempty_o,
  output drt_pkg::rect_t                     rect_o
);
  import drt_pkg::*;

  localparam logic signed [SUM_W-1:0] RowsS = SUM_W'(CANVAS_ROWS);
  localparam logic signed [SUM_W-1:0] ColsS = SUM_W'(CANVAS_COLUMNS);

  logic signed [SUM_W-1:0] top_ext, left_ext;
  logic signed [SUM_W-1:0] bot_sum, right_sum;
  logic signed [SUM_W-1:0] top_c, bot_c, left_c, right_c;

  always_comb begin
    top_ext   = SUM_W'(top_i);
    left_ext  = SUM_W'(left_i);
    bot_sum   = top_ext + SUM_W'(height_i);
    right_sum = left_ext + SUM_W'(width_i);
    top_c     = (top_ext < 0) ? '0 : top_ext;
    left_c    = (left_ext < 0) ? '0 : left_ext;
    bot_c     = (bot_sum > RowsS) ? RowsS : bot_sum;
    right_c   = (right_sum > ColsS) ? ColsS : right_sum;
    nonempty_o = (top_c < bot_c) && (left_c < right_c);
    // When not empty every clipped edge lies between zero and the canvas size.
    rect_o.top    = top_c[COORD_W-1:0];
    rect_o.bottom = bot_c[COORD_W-1:0];
    rect_o.left   = left_c[COORD_W-1:0];
    rect_o.right  = right_c[COORD_W-1:0];
  end

endmodule

[rtl/core/drt_state.sv]
// Dirty box and last-frame time registers, with the union and render logic.
// Depends on drt_pkg.
module drt_state (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  drt_pkg::cmd_e                 cmd_i,
  input  logic [drt_pkg::TIME_W-1:0]    time_i,
  input  logic                          mark_nonempty_i,
  input  drt_pkg::rect_t                mark_rect_i,
  input  logic [drt_pkg::CFG_W-1:0]     frame_interval_i,
  input  logic [drt_pkg::CFG_W-1:0]     fill_colour_i,
  output drt_pkg::result_t              result_o
);
  import drt_pkg::*;

  rect_t             box_q, box_d;
  logic [TIME_W-1:0] last_q, last_d;
  logic              box_exists;
  logic [TIME_W-1:0] elapsed;
  logic              due;

  always_comb begin
    box_exists = box_q.top < box_q.bottom;
    elapsed    = time_i - last_q;
    due        = box_exists && (elapsed >= TIME_W'(frame_interval_i));

    result_o = '0;
    if (due) begin
      result_o.drawn  = 1'b1;
      result_o.top    = box_q.top;
      result_o.height = box_q.bottom - box_q.top;
      result_o.left   = box_q.left;
      result_o.width  = box_q.right - box_q.left;
      result_o.fill   = fill_colour_i;
    end

    box_d  = box_q;
    last_d = last_q;
    if (go_i) begin
      case (cmd_i)
        CMD_BEGIN: begin
          box_d  = '0;
          last_d = time_i - TIME_W'(frame_interval_i);
        end
        CMD_MARK, CMD_MARK_ALL: begin
          if (mark_nonempty_i) begin
            if (!box_exists) begin
              box_d = mark_rect_i;
            end else begin
              if (mark_rect_i.top < box_q.top) box_d.top = mark_rect_i.top;
              if (mark_rect_i.bottom > box_q.bottom) box_d.bottom = mark_rect_i.bottom;
              if (mark_rect_i.left < box_q.left) box_d.left = mark_rect_i.left;
              if (mark_rect_i.right > box_q.right) box_d.right = mark_rect_i.right;
            end
          end
        end
        CMD_RENDER: begin
          if (due) begin
            box_d  = '0;
            last_d = time_i;
          end
        end
        default: begin
          box_d = box_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q  <= '0;
      last_q <= '0;
    end else begin
      box_q  <= box_d;
      last_q <= last_d;
    end
  end

endmodule

[rtl/core/dirty_region_tracker.sv]
// Top level of the dirty region tracker: input register, configuration
// registers, clip and state logic, and the result register. Depends on drt_pkg.
//
// The tracker keeps one dirty bounding box on a canvas of CANVAS_ROWS by
// CANVAS_COLUMNS pixels. Every input transaction carries a command: begin
// clears the box and backdates the last-frame time by frame_interval, mark
// clips the signed rectangle to the canvas and grows the box to cover it,
// mark-all covers the whole canvas, and render returns exactly one result
// transaction. A render result has drawn set, with the box and fill_colour,
// only when a box exists and at least frame_interval milliseconds have passed
// since the last emitted redraw (32-bit wrapping time); otherwise all result
// fields are zero. Only render produces a result. The block takes one
// transaction per cycle while no render stalls: an item sits in the input
// register, where the clip, union and time compare run, and a render result
// is then registered in the output register. The single output register
// sets the throughput limit: while a render result waits there, a following
// render stalls in the input register and holds back the transactions behind
// it, whereas other commands in the input register never wait on the output.
// Configuration writes (0 frame_interval, 1 fill_colour) are always accepted
// and are meant to be issued while no transaction is in flight.
module dirty_region_tracker #(
  parameter int unsigned CANVAS_ROWS    = drt_pkg::DEF_CANVAS_ROWS,
  parameter int unsigned CANVAS_COLUMNS = drt_pkg::DEF_CANVAS_COLUMNS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write channel.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [drt_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [drt_pkg::CFG_W-1:0]            cfg_data_i,
  // Input channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           command_i,
  input  logic [drt_pkg::TIME_W-1:0]           time_ms_i,
  input  logic signed [drt_pkg::FIELD_W-1:0]   rect_top_i,
  input  logic signed [drt_pkg::FIELD_W-1:0]   rect_height_i,
  input  logic signed [drt_pkg::FIELD_W-1:0]   rect_left_i,
  input  logic signed [drt_pkg::FIELD_W-1:0]   rect_width_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 drawn_o,
  output logic [drt_pkg::COORD_W-1:0]          out_top_o,
  output logic [drt_pkg::COORD_W-1:0]          out_height_o,
  output logic [drt_pkg::COORD_W-1:0]          out_left_o,
  output logic [drt_pkg::COORD_W-1:0]          out_width_o,
  output logic [drt_pkg::CFG_W-1:0]            out_fill_o
);
  import drt_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] frame_interval_q, frame_interval_d;
  logic [CFG_W-1:0] fill_colour_q, fill_colour_d;

  // Input register.
  logic                      in_valid_q, in_valid_d;
  cmd_e                      cmd_q;
  logic [TIME_W-1:0]         time_q;
  logic signed [FIELD_W-1:0] top_q, height_q, left_q, width_q;

  // Result register.
  logic    out_valid_q, out_valid_d;
  result_t res_q;

  logic                      out_free;
  logic                      exec_go;
  logic                      in_take;
  logic signed [FIELD_W-1:0] clip_top, clip_height, clip_left, clip_width;
  logic                      mark_nonempty;
  rect_t                     mark_rect;
  result_t                   result;

  // The output register frees up when it is empty or its result is taken in
  // this cycle. Only a render needs it, so other commands never wait on it.
  assign out_free    = !out_valid_q || out_ready_i;
  assign exec_go     = in_valid_q && ((cmd_q != CMD_RENDER) || out_free);
  assign in_ready_o  = !in_valid_q || exec_go;
  assign in_take     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    frame_interval_d = frame_interval_q;
    fill_colour_d    = fill_colour_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_INTERVAL: frame_interval_d = cfg_data_i;
        CFG_FILL_COLOUR:    fill_colour_d    = cfg_data_i;
        default:            frame_interval_d = frame_interval_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_interval_q <= FRAME_INTERVAL_RST;
      fill_colour_q    <= FILL_COLOUR_RST;
    end else begin
      frame_interval_q <= frame_interval_d;
      fill_colour_q    <= fill_colour_d;
    end
  end

  // Input register: the valid flag is control state, the payload is not reset.
  assign in_valid_d = in_take || (in_valid_q && !exec_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q    <= cmd_e'(command_i);
      time_q   <= time_ms_i;
      top_q    <= rect_top_i;
      height_q <= rect_height_i;
      left_q   <= rect_left_i;
      width_q  <= rect_width_i;
    end
  end

  // Mark-all reuses the clipper with the full canvas as its rectangle.
  always_comb begin
    if (cmd_q == CMD_MARK_ALL) begin
      clip_top    = '0;
      clip_height = FIELD_W'(CANVAS_ROWS);
      clip_left   = '0;
      clip_width  = FIELD_W'(CANVAS_COLUMNS);
    end else begin
      clip_top    = top_q;
      clip_height = height_q;
      clip_left   = left_q;
      clip_width  = width_q;
    end
  end

  drt_clip #(
    .CANVAS_ROWS    (CANVAS_ROWS),
    .CANVAS_COLUMNS (CANVAS_COLUMNS)
  ) u_clip (
    .top_i      (clip_top),
    .height_i   (clip_height),
    .left_i     (clip_left),
    .width_i    (clip_width),
    .nonempty_o (mark_nonempty),
    .rect_o     (mark_rect)
  );

  drt_state u_state (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .go_i             (exec_go),
    .cmd_i            (cmd_q),
    .time_i           (time_q),
    .mark_nonempty_i  (mark_nonempty),
    .mark_rect_i      (mark_rect),
    .frame_interval_i (frame_interval_q),
    .fill_colour_i    (fill_colour_q),
    .result_o         (result)
  );

  // Result register: loaded by each executed render, emptied when taken.
  always_comb begin
    if (exec_go && (cmd_q == CMD_RENDER)) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go && (cmd_q == CMD_RENDER)) begin
      res_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign drawn_o      = res_q.drawn;
  assign out_top_o    = res_q.top;
  assign out_height_o = res_q.height;
  assign out_left_o   = res_q.left;
  assign out_width_o  = res_q.width;
  assign out_fill_o   = res_q.fill;

endmodule

[tb/sv/drt_render_checker.sv]
`timescale 1ns / 100ps
// Render result checker for the dirty region tracker testbench.
// It watches the configuration, input and result channels, predicts each
// render result and compares it with the block's output. Depends on drt_pkg.
module drt_render_checker #(
  parameter int unsigned CANVAS_ROWS    = drt_pkg::DEF_CANVAS_ROWS,
  parameter int unsigned CANVAS_COLUMNS = drt_pkg::DEF_CANVAS_COLUMNS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [drt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [drt_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [1:0]                         command_i,
  input  logic [drt_pkg::TIME_W-1:0]         time_ms_i,
  input  logic signed [drt_pkg::FIELD_W-1:0] rect_top_i,
  input  logic signed [drt_pkg::FIELD_W-1:0] rect_height_i,
  input  logic signed [drt_pkg::FIELD_W-1:0] rect_left_i,
  input  logic signed [drt_pkg::FIELD_W-1:0] rect_width_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic                               drawn_i,
  input  logic [drt_pkg::COORD_W-1:0]        out_top_i,
  input  logic [drt_pkg::COORD_W-1:0]        out_height_i,
  input  logic [drt_pkg::COORD_W-1:0]        out_left_i,
  input  logic [drt_pkg::COORD_W-1:0]        out_width_i,
  input  logic [drt_pkg::CFG_W-1:0]          out_fill_i,
  output int unsigned                        mismatch_count_o,
  output int unsigned                        renders_pending_o
);
  import drt_pkg::*;

  localparam logic signed [SUM_W-1:0] ROW_LIMIT = $signed(SUM_W'(CANVAS_ROWS));
  localparam logic signed [SUM_W-1:0] COL_LIMIT = $signed(SUM_W'(CANVAS_COLUMNS));

  logic [COORD_W-1:0] box_top, box_bottom, box_left, box_right;
  logic [TIME_W-1:0]  last_frame;
  logic [CFG_W-1:0]   frame_interval;
  logic [CFG_W-1:0]   fill_colour;
  result_t            expected_renders[$];
  int unsigned        mismatches;

  task automatic clear_box();
    box_top    = '0;
    box_bottom = '0;
    box_left   = '0;
    box_right  = '0;
  endtask

  // Clips a half-open rectangle to the canvas and merges it into the box.
  task automatic grow_box(input logic signed [SUM_W-1:0] row0, input logic signed [SUM_W-1:0] rows,
                          input logic signed [SUM_W-1:0] col0, input logic signed [SUM_W-1:0] cols);
    logic signed [SUM_W-1:0] top, bottom, left, right;
    logic [COORD_W-1:0]      t, b, l, r;
    top    = row0[SUM_W-1] ? '0 : row0;
    left   = col0[SUM_W-1] ? '0 : col0;
    bottom = row0 + rows;
    right  = col0 + cols;
    if (bottom > ROW_LIMIT) bottom = ROW_LIMIT;
    if (right > COL_LIMIT) right = COL_LIMIT;
    if (top >= bottom || left >= right) return;
    t = top[COORD_W-1:0];
    b = bottom[COORD_W-1:0];
    l = left[COORD_W-1:0];
    r = right[COORD_W-1:0];
    if (box_top >= box_bottom) begin
      box_top    = t;
      box_bottom = b;
      box_left   = l;
      box_right  = r;
    end else begin
      if (t < box_top) box_top = t;
      if (b > box_bottom) box_bottom = b;
      if (l < box_left) box_left = l;
      if (r > box_right) box_right = r;
    end
  endtask

  task automatic note_mismatch(input string why, input result_t want, input result_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, why);
      $display("  expected drawn %0d top %0d height %0d left %0d width %0d fill %h",
               want.drawn, want.top, want.height, want.left, want.width, want.fill);
      $display("  actual   drawn %0d top %0d height %0d left %0d width %0d fill %h",
               seen.drawn, seen.top, seen.height, seen.left, seen.width, seen.fill);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t           seen;
    result_t           want;
    logic [TIME_W-1:0] elapsed;
    if (!rst_ni) begin
      clear_box();
      last_frame     = '0;
      frame_interval = FRAME_INTERVAL_RST;
      fill_colour    = FILL_COLOUR_RST;
      expected_renders.delete();
      mismatches     = 0;
    end else begin
      // Results are checked before this edge's input is predicted, since a
      // render accepted now cannot have its result on the output yet.
      if (out_valid_i && out_ready_i) begin
        seen.drawn  = drawn_i;
        seen.top    = out_top_i;
        seen.height = out_height_i;
        seen.left   = out_left_i;
        seen.width  = out_width_i;
        seen.fill   = out_fill_i;
        if (expected_renders.size() == 0) begin
          note_mismatch("render result with no render pending", '0, seen);
        end else begin
          want = expected_renders.pop_front();
          if (seen.drawn !== want.drawn || seen.top !== want.top ||
              seen.height !== want.height || seen.left !== want.left ||
              seen.width !== want.width || seen.fill !== want.fill) begin
            note_mismatch("render result mismatch", want, seen);
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FRAME_INTERVAL: frame_interval = cfg_data_i;
          CFG_FILL_COLOUR:    fill_colour = cfg_data_i;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        case (cmd_e'(command_i))
          CMD_BEGIN: begin
            clear_box();
            last_frame = time_ms_i - TIME_W'(frame_interval);
          end
          CMD_MARK: begin
            grow_box(SUM_W'(rect_top_i), SUM_W'(rect_height_i),
                     SUM_W'(rect_left_i), SUM_W'(rect_width_i));
          end
          CMD_MARK_ALL: begin
            grow_box('0, ROW_LIMIT, '0, COL_LIMIT);
          end
          CMD_RENDER: begin
            elapsed = time_ms_i - last_frame;
            want = '0;
            if (box_top < box_bottom && elapsed >= TIME_W'(frame_interval)) begin
              want.drawn  = 1'b1;
              want.top    = box_top;
              want.height = box_bottom - box_top;
              want.left   = box_left;
              want.width  = box_right - box_left;
              want.fill   = fill_colour;
              clear_box();
              last_frame = time_ms_i;
            end
            expected_renders.push_back(want);
          end
        endcase
      end
    end
    mismatch_count_o  <= mismatches;
    renders_pending_o <= expected_renders.size();
  end

endmodule

[tb/sv/dirty_region_tracker_tb.sv]
`timescale 1ns / 100ps
// Top of the dirty region tracker testbench: clock, reset, stimulus and the
// final verdict. Depends on drt_pkg, dirty_region_tracker and drt_render_checker.
module dirty_region_tracker_tb;
  import drt_pkg::*;

  localparam int unsigned ROWS = DEF_CANVAS_ROWS;
  localparam int unsigned COLS = DEF_CANVAS_COLUMNS;
  // Random transactions per phase; six phases give about 1950 in total.
  localparam int unsigned PHASE_ITEMS = 325;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i;
  logic [CFG_W-1:0]            cfg_data_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [1:0]                  command_i;
  logic [TIME_W-1:0]           time_ms_i;
  logic signed [FIELD_W-1:0]   rect_top_i;
  logic signed [FIELD_W-1:0]   rect_height_i;
  logic signed [FIELD_W-1:0]   rect_left_i;
  logic signed [FIELD_W-1:0]   rect_width_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic                        drawn_o;
  logic [COORD_W-1:0]          out_top_o;
  logic [COORD_W-1:0]          out_height_o;
  logic [COORD_W-1:0]          out_left_o;
  logic [COORD_W-1:0]          out_width_o;
  logic [CFG_W-1:0]            out_fill_o;

  int unsigned mismatch_count;
  int unsigned renders_pending;

  // Idle percentages of the two sides. The receiver's is written with
  // nonblocking assignments because its own process samples it at the edge.
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  // A request that makes the receiver hold off for a long stretch.
  logic        stall_req;
  // Running clock of the canvas and the interval currently programmed, which
  // decides how far time moves between random transactions.
  logic [TIME_W-1:0] now_ms;
  int unsigned       interval_now = FRAME_INTERVAL_RST;

  dirty_region_tracker #(
    .CANVAS_ROWS   (ROWS),
    .CANVAS_COLUMNS(COLS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .time_ms_i    (time_ms_i),
    .rect_top_i   (rect_top_i),
    .rect_height_i(rect_height_i),
    .rect_left_i  (rect_left_i),
    .rect_width_i (rect_width_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drawn_o      (drawn_o),
    .out_top_o    (out_top_o),
    .out_height_o (out_height_o),
    .out_left_o   (out_left_o),
    .out_width_o  (out_width_o),
    .out_fill_o   (out_fill_o)
  );

  drt_render_checker #(
    .CANVAS_ROWS   (ROWS),
    .CANVAS_COLUMNS(COLS)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .command_i        (command_i),
    .time_ms_i        (time_ms_i),
    .rect_top_i       (rect_top_i),
    .rect_height_i    (rect_height_i),
    .rect_left_i      (rect_left_i),
    .rect_width_i     (rect_width_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drawn_i          (drawn_o),
    .out_top_i        (out_top_o),
    .out_height_i     (out_height_o),
    .out_left_i       (out_left_o),
    .out_width_i      (out_width_o),
    .out_fill_i       (out_fill_o),
    .mismatch_count_o (mismatch_count),
    .renders_pending_o(renders_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog. The slowest correct run, with both sides idling heavily and the
  // long receiver hold-off, stays far below this delay.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result receiver. It takes a random decision every cycle, unless a long
  // hold-off has been requested, during which ready stays low so that the
  // block fills up and has to stall its input.
  initial begin
    int unsigned hold;
    hold = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_req) hold = 400;
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Offers one input transaction, after a random number of idle cycles, and
  // returns in the time step of the edge at which it was accepted. Valid is
  // left high so that a back-to-back transaction does not drop it.
  task automatic send_item(input cmd_e cmd, input logic [TIME_W-1:0] stamp,
                           input logic signed [FIELD_W-1:0] top,
                           input logic signed [FIELD_W-1:0] rows,
                           input logic signed [FIELD_W-1:0] left,
                           input logic signed [FIELD_W-1:0] cols);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    time_ms_i     <= stamp;
    rect_top_i    <= top;
    rect_height_i <= rows;
    rect_left_i   <= left;
    rect_width_i  <= cols;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops offering and waits until every predicted render result has come
  // back. The pending count is read only after the edge that follows the last
  // acceptance, so it already includes that transaction. The extra wait at the
  // end lets a trailing non-render transaction leave the input register.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (renders_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes both registers back to back; valid drops only after the second.
  task automatic set_config(input logic [CFG_W-1:0] interval, input logic [CFG_W-1:0] fill);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_FRAME_INTERVAL;
    cfg_data_i  <= interval;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_FILL_COLOUR;
    cfg_data_i  <= fill;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    interval_now = interval;
    @(posedge clk_i);
  endtask

  // One random transaction. Most rectangles lie around the canvas, with
  // offsets on every side, so that clipping, seeding and growing of the box
  // all happen often; the rest use the whole signed range of every field.
  // Time mostly moves by up to twice the frame interval, so that renders
  // fall both before and after the interval has passed, and sometimes jumps
  // anywhere in the 32-bit range.
  task automatic send_random_item();
    cmd_e                      cmd;
    int unsigned               pick;
    logic signed [FIELD_W-1:0] top, rows, left, cols;
    pick = $urandom_range(99);
    if (pick < 6) cmd = CMD_BEGIN;
    else if (pick < 54) cmd = CMD_MARK;
    else if (pick < 59) cmd = CMD_MARK_ALL;
    else cmd = CMD_RENDER;

    case ($urandom_range(9))
      0:       now_ms = $urandom();
      1, 2:    now_ms = now_ms + $urandom_range(3);
      default: now_ms = now_ms + $urandom_range(2 * interval_now + 2);
    endcase

    if ($urandom_range(7) == 0) begin
      top  = FIELD_W'($urandom());
      rows = FIELD_W'($urandom());
      left = FIELD_W'($urandom());
      cols = FIELD_W'($urandom());
    end else begin
      top  = FIELD_W'(int'($urandom_range(ROWS + 60)) - 30);
      rows = FIELD_W'(int'($urandom_range(ROWS / 2 + 20)) - 20);
      left = FIELD_W'(int'($urandom_range(COLS + 60)) - 30);
      cols = FIELD_W'(int'($urandom_range(COLS / 2 + 20)) - 20);
    end
    send_item(cmd, now_ms, top, rows, left, cols);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_FRAME_INTERVAL;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    command_i     <= CMD_BEGIN;
    time_ms_i     <= '0;
    rect_top_i    <= '0;
    rect_height_i <= '0;
    rect_left_i   <= '0;
    rect_width_i  <= '0;
    stall_req     <= 1'b0;
    now_ms         = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset configuration (interval 16, fill 0).
    // Nothing to draw: no box exists yet.
    send_item(CMD_RENDER, 32'd0, '0, '0, '0, '0);
    send_item(CMD_MARK_ALL, 32'd0, '0, '0, '0, '0);
    // Too early: only 5 ms since the reset time stamp.
    send_item(CMD_RENDER, 32'd5, '0, '0, '0, '0);
    // Exactly one interval later the whole canvas is emitted.
    send_item(CMD_RENDER, 32'd16, '0, '0, '0, '0);
    send_item(CMD_BEGIN, 32'd100, '0, '0, '0, '0);
    // Empty or off-canvas rectangles, with the signed field extremes.
    send_item(CMD_MARK, 32'd0, 16'sh8000, 16'sh7FFF, 16'sd0, 16'sd10);
    send_item(CMD_MARK, 32'd0, 16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd10);
    send_item(CMD_MARK, 32'd0, 16'sd10, 16'sd0, 16'sd10, 16'sd10);
    send_item(CMD_MARK, 32'd0, 16'sd10, 16'sd10, 16'sh8000, 16'sh8000);
    send_item(CMD_MARK, 32'd0, 16'sd0, 16'sd10, 16'sd320, 16'sd5);
    send_item(CMD_MARK, 32'd0, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    // Interval has passed since begin, but there is still no box.
    send_item(CMD_RENDER, 32'd100, '0, '0, '0, '0);
    // Clipping at the top-left and bottom-right corners, then the union.
    send_item(CMD_MARK, 32'd0, -16'sd5, 16'sd20, -16'sd7, 16'sd30);
    send_item(CMD_MARK, 32'd0, 16'sd200, 16'sd100, 16'sd300, 16'sd100);
    send_item(CMD_RENDER, 32'd100, '0, '0, '0, '0);
    // A single corner pixel, first too early, then across the time wrap.
    send_item(CMD_MARK, 32'd0, 16'sd239, 16'sd1, 16'sd319, 16'sd1);
    send_item(CMD_RENDER, 32'd110, '0, '0, '0, '0);
    send_item(CMD_RENDER, 32'hFFFF_FFFF, '0, '0, '0, '0);
    // Begin near zero backdates the frame time below zero.
    send_item(CMD_BEGIN, 32'd5, '0, '0, '0, '0);
    send_item(CMD_MARK, 32'd0, 16'sd0, 16'sh7FFF, 16'sd0, 16'sh7FFF);
    send_item(CMD_RENDER, 32'd4, '0, '0, '0, '0);
    send_item(CMD_RENDER, 32'd5, '0, '0, '0, '0);
    // Two disjoint marks grow into their bounding box.
    send_item(CMD_MARK, 32'd0, 16'sd100, 16'sd20, 16'sd50, 16'sd10);
    send_item(CMD_MARK, 32'd0, 16'sd50, 16'sd5, 16'sd200, 16'sd60);
    send_item(CMD_RENDER, 32'd100, '0, '0, '0, '0);
    now_ms = 32'd100;

    // Random part in six phases. The first two let the receiver idle most,
    // the next two the sender, and the last two run without idling. Each
    // phase starts from an idle block with a new register setting.
    for (int phase = 0; phase < 6; phase++) begin
      wait_for_results();
      case (phase)
        0:       set_config(16'd16, CFG_W'($urandom()));
        1:       set_config(16'd0, 16'hFFFF);
        2:       set_config(16'hFFFF, 16'h0000);
        3:       set_config(CFG_W'($urandom_range(200)), CFG_W'($urandom()));
        4:       set_config(CFG_W'($urandom()), CFG_W'($urandom()));
        default: set_config(16'd1, CFG_W'($urandom()));
      endcase
      if (phase < 2) begin
        sender_idle_pct = 30;
        receiver_idle_pct <= 78;
      end else if (phase < 4) begin
        sender_idle_pct = 78;
        receiver_idle_pct <= 30;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct <= 0;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 100) begin
          // The receiver holds off for a long stretch while the sender keeps
          // offering; a waiting render result soon blocks the input.
          stall_req <= 1'b1;
          send_random_item();
          stall_req <= 1'b0;
        end else begin
          if (phase == 2 && n == 150) wait_for_results();
          send_random_item();
        end
      end
    end

    // Let every outstanding render result come back, with a bound.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    for (int c = 0; c < 100000 && renders_pending != 0; c++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && renders_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
